/* src/tmcm_pkg.sv */
// shared constants and types for the tile map collision mover
`default_nettype none
package tmcm_pkg;

  localparam int TILE_SIZE_D = 32;
  localparam int MAP_COLS_D  = 64;
  localparam int MAP_ROWS_D  = 64;

  // pending second halves of split moves
  localparam int STK_D = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MOVE  = 1'b1;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic [1:0] OC_DIRECT = 2'd0;
  localparam logic [1:0] OC_REFINE = 2'd1;
  localparam logic [1:0] OC_SPLIT  = 2'd2;
  localparam logic [1:0] OC_WRITE  = 2'd3;

  typedef struct packed {
    logic req;
    logic wr;
    logic wall;
  } map_ctl_t;

  typedef struct packed {
    logic done;
    logic blocked;
    logic clearing;
  } map_rsp_t;

endpackage
`default_nettype wire

/* src/tmcm_map.sv */
// wall map store (one row of wall bits per word) and box overlap probe
`default_nettype none
module tmcm_map
  import tmcm_pkg::*;
#(
  parameter int TILE_SIZE = TILE_SIZE_D,
  parameter int MAP_COLS  = MAP_COLS_D,
  parameter int MAP_ROWS  = MAP_ROWS_D,
  parameter int PW        = 14,
  parameter int RW        = 6,
  parameter int CLW       = 6
) (
  input  wire                  clk,
  input  wire                  rst,
  input  map_ctl_t             ctl,
  input  wire [RW-1:0]         row,
  input  wire [CLW-1:0]        col,
  input  wire signed [PW-1:0]  px,
  input  wire signed [PW-1:0]  py,
  input  wire [6:0]            bw,
  input  wire [6:0]            bh,
  input  wire signed [PW-1:0]  x_lim,
  input  wire signed [PW-1:0]  y_lim,
  output map_rsp_t             rsp
);

  localparam logic [PW-1:0] RECIP = PW'((1 << PW) / TILE_SIZE);
  localparam int QW = RW + 1;

  typedef enum logic [7:0] {
    M_CLR  = 8'b0000_0001,
    M_IDLE = 8'b0000_0010,
    M_WRD  = 8'b0000_0100,
    M_BND  = 8'b0000_1000,
    M_DIV2 = 8'b0001_0000,
    M_DIV3 = 8'b0010_0000,
    M_ROW  = 8'b0100_0000,
    M_SPARE = 8'b1000_0000
  } mstate_t;

  mstate_t state;

  logic [MAP_COLS-1:0] mem [MAP_ROWS];
  logic [MAP_COLS-1:0] rd_data;
  logic [MAP_COLS-1:0] wd;
  logic [RW-1:0]       ra;
  logic [RW-1:0]       wa;
  logic                we;

  logic [RW-1:0]       clr_row;
  logic [RW-1:0]       w_row;
  logic [CLW-1:0]      w_col;
  logic                w_wall;

  logic signed [PW-1:0] lx, ly, ye;
  logic [6:0]           lw, lh;
  logic [MAP_COLS-1:0]  cmask;
  logic [2*PW-2:0]      prod;
  logic [QW-1:0]        q;
  logic signed [PW-1:0] qb;
  logic [RW-1:0]        r;
  logic signed [PW-1:0] rb;

  logic signed [PW-1:0] xe;
  logic                 outside, empty_box, hit, last_row, step_up;
  logic [QW-1:0]        q_est;
  logic [RW-1:0]        r_corr;
  logic signed [PW-1:0] rb_corr;
  logic [MAP_COLS-1:0]  cm_next;

  assign xe = lx + PW'({1'b0, lw}) - PW'(1);
  assign outside = (lx < 0) || (ly < 0) ||
                   (lx + PW'({1'b0, lw}) > x_lim) || (ly + PW'({1'b0, lh}) > y_lim);
  assign empty_box = (lw == 7'd0) || (lh == 7'd0);
  assign q_est = QW'(prod[2*PW-2:PW]);
  assign step_up = (qb + PW'(TILE_SIZE)) <= ly;
  assign r_corr  = step_up ? RW'(q + QW'(1)) : RW'(q);
  assign rb_corr = step_up ? qb + PW'(TILE_SIZE) : qb;
  assign hit = |(rd_data & cmask);
  assign last_row = (rb + PW'(TILE_SIZE) > ye) || (r == RW'(MAP_ROWS - 1));

  // one lane per tile column: does the box span touch this column
  for (genvar c = 0; c < MAP_COLS; c++) begin : g_col
    localparam logic signed [PW-1:0] LO = PW'(c * TILE_SIZE);
    localparam logic signed [PW-1:0] HI = PW'((c + 1) * TILE_SIZE);
    assign cm_next[c] = (LO <= xe) && (HI > lx);
  end

  always_comb begin
    ra = row;
    case (state)
      M_DIV3:  ra = r_corr;
      M_ROW:   ra = r + RW'(1);
      default: ra = row;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = w_row;
    wd = rd_data;
    case (state)
      M_CLR: begin
        we = 1'b1;
        wa = clr_row;
        wd = '0;
      end
      M_WRD: begin
        we = 1'b1;
        wd[w_col] = w_wall;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_comb begin
    rsp.clearing = (state == M_CLR);
    rsp.done     = 1'b0;
    rsp.blocked  = 1'b0;
    case (state)
      M_WRD: rsp.done = 1'b1;
      M_BND: begin
        rsp.done    = outside || empty_box;
        rsp.blocked = outside;
      end
      M_ROW: begin
        rsp.done    = hit || last_row;
        rsp.blocked = hit;
      end
      default: rsp.done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= M_CLR;
      clr_row <= '0;
    end else begin
      case (state)
        M_CLR: begin
          if (clr_row == RW'(MAP_ROWS - 1)) begin
            state <= M_IDLE;
          end
          clr_row <= clr_row + RW'(1);
        end
        M_IDLE: begin
          w_row  <= row;
          w_col  <= col;
          w_wall <= ctl.wall;
          lx     <= px;
          ly     <= py;
          lw     <= bw;
          lh     <= bh;
          ye     <= py + PW'({1'b0, bh}) - PW'(1);
          if (ctl.req) begin
            state <= ctl.wr ? M_WRD : M_BND;
          end
        end
        M_WRD: state <= M_IDLE;
        M_BND: begin
          prod  <= ly[PW-2:0] * RECIP;
          cmask <= cm_next;
          if (outside || empty_box) begin
            state <= M_IDLE;
          end else begin
            state <= M_DIV2;
          end
        end
        M_DIV2: begin
          q     <= q_est;
          qb    <= PW'(q_est * TILE_SIZE);
          state <= M_DIV3;
        end
        M_DIV3: begin
          r     <= r_corr;
          rb    <= rb_corr;
          state <= M_ROW;
        end
        M_ROW: begin
          if (hit || last_row) begin
            state <= M_IDLE;
          end
          r  <= r + RW'(1);
          rb <= rb + PW'(TILE_SIZE);
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/tile_map_collision_move_top.sv */
// tile map box mover: move sequencer, register port and map store
// a map write returns its word once the map store has written the wall bit
// each probe of a destination stops at the bounds check when out of bounds, else divides and reads each tile row
// a move runs one probe per leaf of the halving tree plus one per refinement pixel step
// start is refused while a word is in flight; results cannot be stalled
// after reset busy stays high while the wall map is cleared row by row
`default_nettype none
module tile_map_collision_move_top
  import tmcm_pkg::*;
#(
  parameter int TILE_SIZE = TILE_SIZE_D,
  parameter int MAP_COLS  = MAP_COLS_D,
  parameter int MAP_ROWS  = MAP_ROWS_D
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire         operation,
  input  wire  [5:0]  tile_col,
  input  wire  [5:0]  tile_row,
  input  wire         wall,
  input  wire  [10:0] pos_x,
  input  wire  [10:0] pos_y,
  input  wire  [6:0]  box_width,
  input  wire  [6:0]  box_height,
  input  wire  [7:0]  vel_x,
  input  wire  [7:0]  vel_y,
  output logic        done,
  output logic [10:0] new_x,
  output logic [10:0] new_y,
  output logic [1:0]  outcome,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MAXD = (MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS;
  localparam int PW   = $clog2(MAXD * TILE_SIZE + 4096) + 1;
  localparam int RW   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int CLW  = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int SPW  = $clog2(STK_D);
  localparam logic signed [8:0] TS_V = 9'(TILE_SIZE);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_LEAF  = 9'b0_0000_0010,
    ST_WHOLE = 9'b0_0000_0100,
    ST_RX    = 9'b0_0000_1000,
    ST_RXW   = 9'b0_0001_0000,
    ST_RY    = 9'b0_0010_0000,
    ST_RYW   = 9'b0_0100_0000,
    ST_NEXT  = 9'b0_1000_0000,
    ST_MAPW  = 9'b1_0000_0000
  } tstate_t;

  tstate_t state;

  logic [6:0] cols_reg, rows_reg;
  logic signed [PW-1:0] x_lim, y_lim;
  logic [8:0] cols_eff, rows_eff;

  logic signed [PW-1:0] bx, by;
  logic [6:0] bw, bh;
  logic [7:0] cur_vx, cur_vy;
  logic [7:0] stk_x [STK_D];
  logic [7:0] stk_y [STK_D];
  logic [SPW:0] sp;
  logic root;
  logic [1:0] outc;
  logic [7:0] cnt;

  map_ctl_t ctl;
  map_rsp_t rsp;
  logic signed [PW-1:0] px, py;

  logic signed [PW-1:0] vxe, vye, sgx, sgy;
  logic [7:0] hx, hy, ax, ay;
  logic split, accept, wr_ok;
  logic [SPW-1:0] top_idx;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROWS) ? {25'd0, rows_reg} : {25'd0, cols_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg <= 7'd64;
      rows_reg <= 7'd64;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_COLS) begin
        cols_reg <= pwdata[6:0];
      end else begin
        rows_reg <= pwdata[6:0];
      end
    end
  end

  // usable map extent in pixels, values above the map size saturate
  assign cols_eff = (9'(cols_reg) > 9'(MAP_COLS)) ? 9'(MAP_COLS) : 9'(cols_reg);
  assign rows_eff = (9'(rows_reg) > 9'(MAP_ROWS)) ? 9'(MAP_ROWS) : 9'(rows_reg);

  always_ff @(posedge clk) begin
    x_lim <= PW'(cols_eff * TILE_SIZE);
    y_lim <= PW'(rows_eff * TILE_SIZE);
  end

  assign vxe = PW'($signed(cur_vx));
  assign vye = PW'($signed(cur_vy));
  assign sgx = cur_vx[7] ? -PW'(1) : PW'(1);
  assign sgy = cur_vy[7] ? -PW'(1) : PW'(1);
  // halving truncates toward zero
  assign hx = 8'($signed(cur_vx + 8'(cur_vx[7])) >>> 1);
  assign hy = 8'($signed(cur_vy + 8'(cur_vy[7])) >>> 1);
  assign ax = cur_vx[7] ? 8'(-cur_vx) : cur_vx;
  assign ay = cur_vy[7] ? 8'(-cur_vy) : cur_vy;
  assign split = ($signed({cur_vx[7], cur_vx}) >= TS_V) ||
                 ($signed({cur_vy[7], cur_vy}) >= TS_V);
  assign top_idx = SPW'(sp - (SPW+1)'(1));

  assign busy   = (state != ST_IDLE) || rsp.clearing;
  assign accept = start && !busy;
  assign wr_ok  = (9'(tile_col) < 9'(MAP_COLS)) && (9'(tile_row) < 9'(MAP_ROWS));

  always_comb begin
    ctl.req  = 1'b0;
    ctl.wr   = 1'b0;
    ctl.wall = wall;
    px = bx;
    py = by;
    case (state)
      ST_IDLE: begin
        ctl.req = accept && (operation == OP_WRITE) && wr_ok;
        ctl.wr  = 1'b1;
      end
      ST_LEAF: begin
        ctl.req = !split;
        px = bx + vxe;
        py = by + vye;
      end
      ST_RX: begin
        ctl.req = (cnt != 8'd0);
        px = bx + sgx;
      end
      ST_RY: begin
        ctl.req = (cnt != 8'd0);
        py = by + sgy;
      end
      default: ctl.req = 1'b0;
    endcase
  end

  tmcm_map #(
    .TILE_SIZE (TILE_SIZE),
    .MAP_COLS  (MAP_COLS),
    .MAP_ROWS  (MAP_ROWS),
    .PW        (PW),
    .RW        (RW),
    .CLW       (CLW)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .row   (RW'(tile_row)),
    .col   (CLW'(tile_col)),
    .px    (px),
    .py    (py),
    .bw    (bw),
    .bh    (bh),
    .x_lim (x_lim),
    .y_lim (y_lim),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      sp    <= '0;
      root  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          bx     <= PW'(pos_x);
          by     <= PW'(pos_y);
          bw     <= box_width;
          bh     <= box_height;
          cur_vx <= vel_x;
          cur_vy <= vel_y;
          sp     <= '0;
          root   <= 1'b1;
          if (accept) begin
            if (operation == OP_MOVE) begin
              state <= ST_LEAF;
            end else if (wr_ok) begin
              state <= ST_MAPW;
            end else begin
              done    <= 1'b1;
              new_x   <= '0;
              new_y   <= '0;
              outcome <= OC_WRITE;
            end
          end
        end
        ST_MAPW: begin
          if (rsp.done) begin
            done    <= 1'b1;
            new_x   <= '0;
            new_y   <= '0;
            outcome <= OC_WRITE;
            state   <= ST_IDLE;
          end
        end
        ST_LEAF: begin
          if (split) begin
            stk_x[sp[SPW-1:0]] <= 8'(cur_vx - hx);
            stk_y[sp[SPW-1:0]] <= 8'(cur_vy - hy);
            sp     <= sp + (SPW+1)'(1);
            cur_vx <= hx;
            cur_vy <= hy;
            if (root) begin
              outc <= OC_SPLIT;
            end
            root <= 1'b0;
          end else begin
            state <= ST_WHOLE;
          end
        end
        ST_WHOLE: begin
          if (rsp.done) begin
            if (!rsp.blocked) begin
              bx <= bx + vxe;
              by <= by + vye;
              if (root) begin
                outc <= OC_DIRECT;
              end
              state <= ST_NEXT;
            end else begin
              if (root) begin
                outc <= OC_REFINE;
              end
              cnt   <= ax;
              state <= ST_RX;
            end
          end
        end
        ST_RX: begin
          if (cnt == 8'd0) begin
            cnt   <= ay;
            state <= ST_RY;
          end else begin
            state <= ST_RXW;
          end
        end
        ST_RXW: begin
          if (rsp.done) begin
            if (rsp.blocked) begin
              cnt   <= ay;
              state <= ST_RY;
            end else begin
              bx    <= bx + sgx;
              cnt   <= cnt - 8'd1;
              state <= ST_RX;
            end
          end
        end
        ST_RY: begin
          state <= (cnt == 8'd0) ? ST_NEXT : ST_RYW;
        end
        ST_RYW: begin
          if (rsp.done) begin
            if (rsp.blocked) begin
              state <= ST_NEXT;
            end else begin
              by    <= by + sgy;
              cnt   <= cnt - 8'd1;
              state <= ST_RY;
            end
          end
        end
        ST_NEXT: begin
          root <= 1'b0;
          if (sp == '0) begin
            done    <= 1'b1;
            new_x   <= bx[10:0];
            new_y   <= by[10:0];
            outcome <= outc;
            state   <= ST_IDLE;
          end else begin
            cur_vx <= stk_x[top_idx];
            cur_vy <= stk_y[top_idx];
            sp     <= sp - (SPW+1)'(1);
            state  <= ST_LEAF;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a result word is only emitted on the way back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe outside idle");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= (SPW+1)'(STK_D))
    else $error("split stack overflow");

  // the map only answers while the sequencer waits on it
  a_rsp_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == ST_WHOLE || state == ST_RXW || state == ST_RYW ||
                  state == ST_MAPW))
    else $error("map answer with no probe pending");

  a_no_start_clear: assert property (@(posedge clk) disable iff (rst)
    rsp.clearing |-> (state == ST_IDLE) && !ctl.req)
    else $error("map request during clearing pass");

endmodule
`default_nettype wire

/* tb/tile_map_collision_move_top_test.sv */
// self-checking testbench for the tile map collision mover
`timescale 1ns / 1ps
module tile_map_collision_move_top_test;
  import tmcm_pkg::*;

  typedef struct {
    logic [10:0] x;
    logic [10:0] y;
    logic [1:0]  oc;
  } move_word_t;

  // predicts results of the mover and checks each done word
  class move_scoreboard;
    bit          walls [64][64];
    int          cols_used;
    int          rows_used;
    int          bx, by, bw, bh;
    move_word_t  pending [$];
    int          errors;

    function void clear_map();
      foreach (walls[r, c]) walls[r][c] = 0;
      cols_used = 64;
      rows_used = 64;
      errors = 0;
    endfunction

    function bit is_blocked(int x, int y);
      int cc, rr, c0, c1, r0, r1;
      cc = cols_used > 64 ? 64 : cols_used;
      rr = rows_used > 64 ? 64 : rows_used;
      if (x < 0 || y < 0 || x + bw - 1 >= cc * 32 || y + bh - 1 >= rr * 32) return 1;
      if (bw <= 0 || bh <= 0) return 0;
      c0 = x / 32; c1 = (x + bw - 1) / 32;
      r0 = y / 32; r1 = (y + bh - 1) / 32;
      for (int c = c0; c <= c1; c++)
        for (int r = r0; r <= r1; r++)
          if (c < 64 && r < 64 && walls[r][c]) return 1;
      return 0;
    endfunction

    function bit step_to(int dx, int dy);
      if (is_blocked(bx + dx, by + dy)) return 0;
      bx += dx;
      by += dy;
      return 1;
    endfunction

    function logic [1:0] run_move(int vx, int vy);
      int sx, sy;
      logic [1:0] tmp;
      if (vx >= 32 || vy >= 32) begin
        tmp = run_move(vx / 2, vy / 2);
        tmp = run_move(vx - vx / 2, vy - vy / 2);
        return OC_SPLIT;
      end
      if (step_to(vx, vy)) return OC_DIRECT;
      sx = vx > 0 ? 1 : (vx < 0 ? -1 : 0);
      sy = vy > 0 ? 1 : (vy < 0 ? -1 : 0);
      for (int i = 0; i < (vx < 0 ? -vx : vx); i++)
        if (!step_to(sx, 0)) break;
      for (int i = 0; i < (vy < 0 ? -vy : vy); i++)
        if (!step_to(0, sy)) break;
      return OC_REFINE;
    endfunction

    function void note_word(logic op, logic [5:0] tc, logic [5:0] tr, logic wl,
                            logic [10:0] px, logic [10:0] py, logic [6:0] w,
                            logic [6:0] h, logic signed [7:0] vx,
                            logic signed [7:0] vy);
      move_word_t m;
      if (op == OP_WRITE) begin
        walls[tr][tc] = wl;
        m.x = 0; m.y = 0; m.oc = OC_WRITE;
      end else begin
        bx = px; by = py; bw = w; bh = h;
        m.oc = run_move(vx, vy);
        m.x = bx[10:0];
        m.y = by[10:0];
      end
      pending.push_back(m);
    endfunction

    function void check_word(logic [10:0] x, logic [10:0] y, logic [1:0] oc);
      move_word_t m;
      if (pending.size() == 0) begin
        $display("%0t unexpected word x=%0d y=%0d oc=%0d", $time, x, y, oc);
        errors++;
        return;
      end
      m = pending.pop_front();
      if (x !== m.x) begin
        $display("%0t new_x expected %0d actual %0d", $time, m.x, x);
        errors++;
      end
      if (y !== m.y) begin
        $display("%0t new_y expected %0d actual %0d", $time, m.y, y);
        errors++;
      end
      if (oc !== m.oc) begin
        $display("%0t outcome expected %0d actual %0d", $time, m.oc, oc);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic operation = 0;
  logic [5:0] tile_col = 0, tile_row = 0;
  logic wall = 0;
  logic [10:0] pos_x = 0, pos_y = 0;
  logic [6:0] box_width = 1, box_height = 1;
  logic [7:0] vel_x = 0, vel_y = 0;
  logic done;
  logic [10:0] new_x, new_y;
  logic [1:0] outcome;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  move_scoreboard sb;
  int cycles = 0;
  localparam int CYCLE_LIMIT = 5000000;

  tile_map_collision_move_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .tile_col(tile_col), .tile_row(tile_row), .wall(wall), .pos_x(pos_x),
    .pos_y(pos_y), .box_width(box_width), .box_height(box_height),
    .vel_x(vel_x), .vel_y(vel_y), .done(done), .new_x(new_x), .new_y(new_y),
    .outcome(outcome), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_word(new_x, new_y, outcome);
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [6:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_COLS) sb.cols_used = value;
    else sb.rows_used = value;
  endtask

  task automatic send_word(logic op, logic [5:0] tc, logic [5:0] tr, logic wl,
                           logic [10:0] px, logic [10:0] py, logic [6:0] w,
                           logic [6:0] h, logic [7:0] vx, logic [7:0] vy);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
    repeat (gap) @(posedge clk);
    start <= 1; operation <= op; tile_col <= tc; tile_row <= tr; wall <= wl;
    pos_x <= px; pos_y <= py; box_width <= w; box_height <= h;
    vel_x <= vx; vel_y <= vy;
    do @(posedge clk); while (busy);
    sb.note_word(op, tc, tr, wl, px, py, w, h, vx, vy);
    start <= 0;
    // the block is busy for at least this cycle after taking a word
    @(posedge clk);
  endtask

  task automatic tile(logic [5:0] c, logic [5:0] r, logic wl);
    send_word(OP_WRITE, c, r, wl, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom);
  endtask

  task automatic move(logic [10:0] px, logic [10:0] py, logic [6:0] w,
                      logic [6:0] h, logic [7:0] vx, logic [7:0] vy);
    send_word(OP_MOVE, $urandom, $urandom, $urandom, px, py, w, h, vx, vy);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int span;
    span = 32 * (sb.cols_used > 64 ? 64 : (sb.cols_used == 0 ? 1 : sb.cols_used));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        tile($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 2) == 0);
      else if ($urandom_range(0, 15) == 0)
        move($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        move($urandom_range(0, span > 330 ? 330 : span), $urandom_range(0, 330),
             $urandom_range(0, 64), $urandom_range(0, 64), $urandom, $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.clear_map();
    repeat (10) @(posedge clk);
    rst <= 0;
    // directed words
    move(0, 0, 1, 1, 8'd5, 8'd5);
    move(2047, 2047, 127, 127, 8'd1, 8'd1);
    move(0, 0, 0, 0, 8'h80, 8'h80);
    move(100, 100, 64, 64, 8'd127, 8'd127);
    move(100, 100, 64, 64, 8'd31, 8'h81);
    move(3000 % 2048, 10, 8, 8, 8'd0, 8'd0);
    tile(6'd63, 6'd63, 1);
    tile(6'd3, 6'd3, 1);
    tile(6'd0, 6'd0, 0);
    move(40, 40, 16, 16, 8'd60, 8'd60);
    move(120, 120, 10, 10, 8'hF0, 8'hF0);
    move(50, 50, 0, 20, 8'd10, 8'd10);
    move(2000, 2000, 40, 40, 8'd20, 8'd30);
    move(1, 1, 64, 64, 8'hFE, 8'd2);
    drain();
    write_reg(REG_COLS, 7'd127);
    write_reg(REG_ROWS, 7'd1);
    move(10, 0, 8, 8, 8'd3, 8'd40);
    move(2040, 0, 8, 8, 8'd10, 8'd0);
    drain();
    write_reg(REG_COLS, 7'd0);
    move(10, 10, 4, 4, 8'd1, 8'd1);
    drain();
    write_reg(REG_COLS, 7'd8);
    write_reg(REG_ROWS, 7'd10);
    random_phase(150);
    drain();
    write_reg(REG_COLS, 7'd1);
    write_reg(REG_ROWS, 7'd64);
    random_phase(80);
    drain();
    write_reg(REG_COLS, 7'd64);
    write_reg(REG_ROWS, 7'd127);
    random_phase(200);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
